>>> sv/lrlv_pkg.sv
// shared types, constants and arithmetic helpers for the led ring visualizer
// no dependencies
`default_nettype none
package lrlv_pkg;

	localparam int MAX_RING_LEDS = 64;
	localparam int LEVEL_MAX     = 1024;
	localparam int CFG_DW        = 8;

	typedef enum logic [1:0] {
		REG_LED_COUNT = 2'd0,
		REG_PEAK      = 2'd1,
		REG_IDLE      = 2'd2,
		REG_RATE      = 2'd3
	} reg_idx_t;

	// one classified frame handed from front to back
	typedef struct packed {
		logic        active;
		logic [10:0] smooth;
		logic [6:0]  count;
		logic [5:0]  phase;
		logic [7:0]  peak;
		logic [7:0]  idle;
	} frame_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SETUP,
		BK_DIV_SPAN,
		BK_LED,
		BK_DIV_LED,
		BK_EMIT
	} bk_state_t;

	// colour wheel on an 8-bit hue
	function automatic logic [23:0] wheel(input logic [7:0] pos);
		logic [7:0] p;
		logic [9:0] t;
		begin
			if (pos < 8'd85) begin
				t = 10'(pos) * 10'd3;
				wheel = {8'd255 - t[7:0], t[7:0], 8'd0};
			end else if (pos < 8'd170) begin
				p = pos - 8'd85;
				t = 10'(p) * 10'd3;
				wheel = {8'd0, 8'd255 - t[7:0], t[7:0]};
			end else begin
				p = pos - 8'd170;
				t = 10'(p) * 10'd3;
				wheel = {t[7:0], 8'd0, 8'd255 - t[7:0]};
			end
		end
	endfunction

	// x / 255 for x < 65280
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] q;
		begin
			q = (17'(x) + 17'd1 + 17'(x >> 8)) >> 8;
			div255 = q[7:0];
		end
	endfunction

endpackage
`default_nettype wire

>>> sv/lrlv_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on nothing
`default_nettype none
module lrlv_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] dividend,
	input  wire logic [7:0]  divisor,
	output logic             done,
	output logic [15:0]      quotient
);
	logic [15:0] q_q;
	logic [8:0]  rem_q;
	logic [7:0]  den_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [9:0]  trial;

	assign trial = {rem_q, q_q[15]} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!trial[9]) begin
				rem_q <= trial[8:0];
				q_q   <= {q_q[14:0], 1'b1};
			end else begin
				rem_q <= {rem_q[7:0], q_q[15]};
				q_q   <= {q_q[14:0], 1'b0};
			end
		end
	end

	assign quotient = q_q;
endmodule
`default_nettype wire

>>> sv/lrlv_front.sv
// front part: accepts ticks, updates envelope, phase and miss count
// depends on lrlv_pkg
`default_nettype none
module lrlv_front #(
	parameter int MaxLeds = lrlv_pkg::MAX_RING_LEDS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              source_opened,
	input  wire logic              source_failed,
	input  wire logic [10:0]       level,
	input  wire logic [6:0]        ring_leds,
	input  wire logic [7:0]        peak_brightness,
	input  wire logic [7:0]        dim_level,
	input  wire logic [5:0]        frame_rate,
	output logic                   q_valid,
	input  wire logic              q_take,
	output lrlv_pkg::frame_t       q_frame
);
	localparam logic [6:0] MaxC = 7'(MaxLeds > 64 ? 64 : MaxLeds);

	logic [10:0] smooth_q;
	logic [5:0]  phase_q;
	logic [10:0] miss_q;
	// two-entry queue
	lrlv_pkg::frame_t fifo_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  fill_q;

	logic [6:0]  cnt;
	logic [5:0]  ph;
	logic [10:0] miss_n, lvl, s_n, d;
	logic [11:0] up;
	logic [21:0] prod3;
	logic [19:0] prod12;
	logic        act;
	logic [6:0]  ph_inc;
	logic        accept;

	always_comb begin
		cnt = ring_leds;
		if (cnt == 7'd0) cnt = 7'd1;
		if (cnt > MaxC) cnt = MaxC;
		ph = (7'(phase_q) >= cnt) ? 6'd0 : phase_q;
		miss_n = source_opened ? 11'd0 : miss_q;
		if (source_failed && miss_n != 11'd2047) miss_n = miss_n + 11'd1;
		lvl = source_failed ? 11'd0 : level;
		if (lvl > 11'd1024) lvl = 11'd1024;
		up = '0;
		d  = '0;
		prod3  = '0;
		prod12 = '0;
		if (lvl != 11'd0) begin
			if (lvl > smooth_q) begin
				// x/3 as x*683>>11, exact for x up to 2045
				prod3 = 22'(lvl - smooth_q) * 22'd683;
				up = 12'(smooth_q) + 12'(prod3[21:11]) + 12'd1;
				s_n = (up > 12'd1024) ? 11'd1024 : up[10:0];
			end else begin
				d = ((smooth_q - lvl) >> 3) + 11'd1;
				s_n = (d > smooth_q) ? 11'd0 : smooth_q - d;
			end
		end else begin
			// s/12 as (s>>2)/3
			prod12 = 20'(smooth_q >> 2) * 20'd683;
			d = 11'(prod12[19:11]) + 11'd1;
			s_n = (d > smooth_q) ? 11'd0 : smooth_q - d;
		end
		act = (lvl != 11'd0) || (s_n > 11'd8);
		if (14'(miss_n) > 14'(frame_rate) * 14'd30) act = 1'b0;
		ph_inc = 7'(ph) + 7'd1;
		if (ph_inc >= cnt) ph_inc = 7'd0;
	end

	assign in_stall = (fill_q == 2'd2);
	assign accept   = in_valid && !in_stall;
	assign q_valid  = (fill_q != 2'd0);
	assign q_frame  = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= '0;
			phase_q  <= '0;
			miss_q   <= '0;
			wr_q     <= 1'b0;
			rd_q     <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (accept) begin
				smooth_q <= s_n;
				phase_q  <= ph_inc[5:0];
				miss_q   <= miss_n;
				wr_q     <= !wr_q;
			end
			if (q_take && q_valid) rd_q <= !rd_q;
			fill_q <= fill_q + 2'(accept) - 2'(q_take && q_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			fifo_q[wr_q] <= '{active: act, smooth: s_n, count: cnt, phase: ph,
				peak: peak_brightness, idle: dim_level};
	end
endmodule
`default_nettype wire

>>> sv/lrlv_back.sv
// back part: renders one frame into per-led color beats
// depends on lrlv_pkg and lrlv_div
`default_nettype none
module lrlv_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_valid,
	output logic              q_take,
	input  wire lrlv_pkg::frame_t q_frame,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [5:0]        led_index,
	output logic [7:0]        red,
	output logic [7:0]        green,
	output logic [7:0]        blue,
	output logic              last_led
);
	lrlv_pkg::bk_state_t st_q, st_n;
	lrlv_pkg::frame_t    f_q;
	logic [7:0]  span_q, amb_q;
	logic [6:0]  i_q;
	logic [7:0]  dist_q, bright_q;
	logic        div_start;
	logic [15:0] div_a;
	logic [7:0]  div_b;
	logic        div_done;
	logic [15:0] div_qt;

	lrlv_div u_div (.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quotient(div_qt));

	logic [17:0] sc;
	logic [7:0]  lit, d0, hue;
	logic [18:0] amb_p;
	logic [6:0]  dd;
	logic [13:0] hoff;
	logic [23:0] rgb;
	logic [8:0]  loc;
	logic [7:0]  b_n;

	always_comb begin
		sc = 18'(f_q.smooth) * 18'(f_q.count) + 18'd1023;
		lit = 8'(sc >> 10);
		if (f_q.active && lit == 8'd0) lit = 8'd1;
		amb_p = 19'(f_q.smooth) * 19'(f_q.idle);
		dd = (i_q > 7'(f_q.phase)) ? i_q - 7'(f_q.phase) : 7'(f_q.phase) - i_q;
		if (dd > (f_q.count >> 1)) dd = f_q.count - dd;
		d0 = 8'(dd);
		hoff = 14'(i_q) << 8;
	end

	// divider is used for span-independent hue offset and brightness falloff
	always_comb begin
		div_start = 1'b0;
		div_a = '0;
		div_b = 8'd1;
		q_take = 1'b0;
		st_n = st_q;
		case (st_q)
			lrlv_pkg::BK_IDLE: if (q_valid) begin
				q_take = 1'b1;
				st_n = lrlv_pkg::BK_SETUP;
			end
			lrlv_pkg::BK_SETUP: st_n = lrlv_pkg::BK_LED;
			lrlv_pkg::BK_LED: begin
				div_start = 1'b1;
				div_a = 16'(hoff);
				div_b = 8'(f_q.count);
				st_n = lrlv_pkg::BK_DIV_SPAN;
			end
			lrlv_pkg::BK_DIV_SPAN: if (div_done) begin
				div_start = 1'b1;
				div_a = 16'(dist_q) * 16'(f_q.peak);
				div_b = span_q;
				st_n = lrlv_pkg::BK_DIV_LED;
			end
			lrlv_pkg::BK_DIV_LED: if (div_done) st_n = lrlv_pkg::BK_EMIT;
			lrlv_pkg::BK_EMIT: if (!out_stall) begin
				if (i_q == f_q.count - 7'd1) st_n = lrlv_pkg::BK_IDLE;
				else st_n = lrlv_pkg::BK_LED;
			end
			default: st_n = lrlv_pkg::BK_IDLE;
		endcase
	end

	logic [7:0] hue_q;
	always_comb begin
		hue = 8'(8'(f_q.phase) * 8'd7 + 8'(div_qt));
		loc = 9'(f_q.peak) - 9'(div_qt[7:0]);
		b_n = amb_q;
		if (f_q.active && dist_q < span_q) begin
			if (loc[7:0] > b_n) b_n = loc[7:0];
		end else if (!f_q.active && dist_q == 8'd0) b_n = f_q.idle;
		rgb = lrlv_pkg::wheel(hue_q);
	end

	assign out_valid = (st_q == lrlv_pkg::BK_EMIT);
	assign led_index = i_q[5:0];
	assign last_led  = (i_q == f_q.count - 7'd1);
	assign red   = lrlv_pkg::div255(16'(rgb[23:16]) * 16'(bright_q));
	assign green = lrlv_pkg::div255(16'(rgb[15:8]) * 16'(bright_q));
	assign blue  = lrlv_pkg::div255(16'(rgb[7:0]) * 16'(bright_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= lrlv_pkg::BK_IDLE;
			i_q  <= '0;
		end else begin
			st_q <= st_n;
			if (st_q == lrlv_pkg::BK_IDLE) i_q <= '0;
			else if (st_q == lrlv_pkg::BK_EMIT && !out_stall) i_q <= i_q + 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) f_q <= q_frame;
		if (st_q == lrlv_pkg::BK_SETUP) begin
			span_q <= (lit >> 1) + 8'd1;
			amb_q  <= f_q.active ? 8'(amb_p >> 10) : 8'd0;
		end
		if (st_q == lrlv_pkg::BK_LED) dist_q <= d0;
		if (st_q == lrlv_pkg::BK_DIV_SPAN && div_done) hue_q <= hue;
		if (st_q == lrlv_pkg::BK_DIV_LED && div_done) bright_q <= b_n;
	end
endmodule
`default_nettype wire

>>> sv/led_ring_level_visualizer_core.sv
// led ring visualizer top: front classifier, frame queue, back renderer
// each led beat takes two divider passes, hue offset then brightness falloff
// a new led starts only after the previous led beat is taken by the output
// the back renderer takes a new frame only after the last led beat of its frame; two ticks can wait in the queue
// reset: asynchronous, clears envelope, phase, miss count and registers to defaults
`default_nettype none
module led_ring_level_visualizer_core #(
	parameter int MaxRingLeds = lrlv_pkg::MAX_RING_LEDS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        source_opened,
	input  wire logic        source_failed,
	input  wire logic [10:0] level,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [5:0]       led_index,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic             last_led
);
	logic [6:0] led_count_q;
	logic [7:0] peak_q, idle_q;
	logic [5:0] rate_q;
	logic       q_valid, q_take;
	lrlv_pkg::frame_t q_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_count_q <= 7'd32;
			peak_q      <= 8'd255;
			idle_q      <= 8'd6;
			rate_q      <= 6'd20;
		end else if (cfg_we) begin
			case (lrlv_pkg::reg_idx_t'(cfg_index))
				lrlv_pkg::REG_LED_COUNT: led_count_q <= cfg_data[6:0];
				lrlv_pkg::REG_PEAK:      peak_q <= cfg_data;
				lrlv_pkg::REG_IDLE:      idle_q <= cfg_data;
				lrlv_pkg::REG_RATE:      rate_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	lrlv_front #(.MaxLeds(MaxRingLeds)) u_front (.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .source_opened(source_opened),
		.source_failed(source_failed), .level(level), .ring_leds(led_count_q),
		.peak_brightness(peak_q), .dim_level(idle_q), .frame_rate(rate_q),
		.q_valid(q_valid), .q_take(q_take), .q_frame(q_frame));

	lrlv_back u_back (.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_take(q_take),
		.q_frame(q_frame), .out_valid(out_valid), .out_stall(out_stall),
		.led_index(led_index), .red(red), .green(green), .blue(blue),
		.last_led(last_led));

	// a stalled beat keeps its led index and red value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(led_index) && $stable(red))
		else $error("led beat changed while stalled");
	// queue is only drained when it holds a frame
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid) else $error("frame taken from empty queue");
	// the last beat of a frame never carries a phantom index
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_led |-> led_index <= 6'(MaxRingLeds - 1))
		else $error("last led index out of range");
endmodule
`default_nettype wire
